FILE: rtl/core/qlm_pkg.sv
// Shared constants, field widths and status codes of the queued lock manager.
package qlm_pkg;

	localparam int LOCK_COUNT = 16;
	localparam int NODE_COUNT = 64;

	localparam int IDX_W  = 4;
	localparam int NODE_W = 6;
	localparam int LOCK_W = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
	localparam int PTR_W  = $clog2(NODE_COUNT);
	localparam int CNT_W  = PTR_W + 1;
	localparam int ADDR_W = LOCK_W + PTR_W;
	localparam int MEM_DEPTH = LOCK_COUNT * NODE_COUNT;

	typedef enum logic [0:0] {
		ACT_ACQUIRE = 1'b0,
		ACT_RELEASE = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_WAITING  = 3'd1,
		ST_HANDOFF  = 3'd2,
		ST_RELEASED = 3'd3,
		ST_REFUSED  = 3'd4
	} status_t;

endpackage

FILE: rtl/core/queued_lock_manager.sv
// Lock table with per-lock waiter queues, one request transfer per cycle while results are taken.
//
//  channel | dir | handshake          | tuser             | tdata (lowest bit up)
//  s_*     | in  | s_tvalid/s_tready  | action            | lock_index, requester_node
//  m_*     | out | m_tvalid/m_tready  | status            | next_owner
//
//  One request per cycle sustained while results are taken; a request passes stage 1, then stage 2.
//  Stage 1 holds the request and updates the per-lock flags and pointers; stage 2 holds
//  the status and the waiter read from the single-port-per-side waiter memory.
//  Reset clears every held flag and queue pointer at once; the waiter memory is not
//  cleared, since an entry is only read after it has been written.
//  A stalled result holds both stages; the input stays ready while stage 1 is free.
module queued_lock_manager
	import qlm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [0:0]  s_tuser,   // action
	input  logic [15:0] s_tdata,   // lock_index[3:0], requester_node[9:4], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [2:0]  m_tuser,   // status
	output logic [7:0]  m_tdata    // next_owner[5:0], zero pad
);

	// per-lock state
	logic             held_q [LOCK_COUNT];
	logic [PTR_W-1:0] head_q [LOCK_COUNT];
	logic [PTR_W-1:0] tail_q [LOCK_COUNT];
	logic [CNT_W-1:0] cnt_q  [LOCK_COUNT];

	logic [NODE_W-1:0] waiter_mem [MEM_DEPTH];

	logic              v_s1;
	action_t           act_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [NODE_W-1:0] node_s1;

	logic              v_s2;
	status_t           status_s2;
	logic [NODE_W-1:0] owner_s2;

	logic              adv;
	logic              fire;
	logic [LOCK_W-1:0] slot;
	logic              lock_ok;
	logic              held;
	logic [PTR_W-1:0]  head;
	logic [PTR_W-1:0]  tail;
	logic [CNT_W-1:0]  cnt;
	status_t           status;
	logic              push;
	logic              pop;
	logic              take;
	logic              drop;

	assign adv      = !v_s2 || m_tready;
	assign fire     = v_s1 && adv;
	assign s_tready = !v_s1 || adv;

	assign slot    = idx_s1[LOCK_W-1:0];
	assign lock_ok = {1'b0, idx_s1} < (IDX_W + 1)'(LOCK_COUNT);
	assign held    = held_q[slot];
	assign head    = head_q[slot];
	assign tail    = tail_q[slot];
	assign cnt     = cnt_q[slot];

	always_comb begin
		status = ST_REFUSED;
		push   = 1'b0;
		pop    = 1'b0;
		take   = 1'b0;
		drop   = 1'b0;
		priority if (!lock_ok) begin
			status = ST_REFUSED;
		end else if (act_s1 == ACT_ACQUIRE) begin
			priority if (!held) begin
				status = ST_GRANTED;
				take   = 1'b1;
			end else if (cnt == CNT_W'(NODE_COUNT)) begin
				status = ST_REFUSED;
			end else begin
				status = ST_WAITING;
				push   = 1'b1;
			end
		end else begin
			priority if (cnt != '0) begin
				status = ST_HANDOFF;
				pop    = 1'b1;
			end else begin
				status = ST_RELEASED;
				drop   = 1'b1;
			end
		end
	end

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		wrap_inc = (p == PTR_W'(NODE_COUNT - 1)) ? '0 : p + 1'b1;
	endfunction

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready)
				v_s1 <= s_tvalid;
			if (adv)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_s1  <= action_t'(s_tuser);
			idx_s1  <= s_tdata[IDX_W-1:0];
			node_s1 <= s_tdata[IDX_W+NODE_W-1:IDX_W];
		end
		if (fire)
			status_s2 <= status;
	end

	// lock table update as the request leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOCK_COUNT; i++) begin
				held_q[i] <= 1'b0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (fire) begin
			if (take)
				held_q[slot] <= 1'b1;
			if (drop)
				held_q[slot] <= 1'b0;
			if (push) begin
				tail_q[slot] <= wrap_inc(tail);
				cnt_q[slot]  <= cnt + 1'b1;
			end
			if (pop) begin
				head_q[slot] <= wrap_inc(head);
				cnt_q[slot]  <= cnt - 1'b1;
			end
		end
	end

	// waiter memory: write the tail on enqueue, read the head for every request
	always_ff @(posedge clk) begin
		if (fire && push)
			waiter_mem[{slot, tail}] <= node_s1;
		if (fire)
			owner_s2 <= waiter_mem[{slot, head}];
	end

	assign m_tvalid = v_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = {(8 - NODE_W)'(0), (status_s2 == ST_HANDOFF) ? owner_s2 : NODE_W'(0)};

endmodule

FILE: rtl/core/qlm_checker.sv
// Port-level checks of the queued lock manager, bound to the top level.
module qlm_checker
	import qlm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [0:0]  s_tuser,
	input logic [15:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [2:0]  m_tuser,
	input logic [7:0]  m_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser) && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_owner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_HANDOFF) |-> m_tdata == '0)
		else $error("next owner set on a result other than handoff");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_GRANTED) || (m_tuser == ST_WAITING) ||
			(m_tuser == ST_HANDOFF) || (m_tuser == ST_RELEASED) ||
			(m_tuser == ST_REFUSED))
		else $error("status code out of range");

	// an empty output stage always leaves room for a new transfer
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with the output stage empty");

endmodule

bind queued_lock_manager qlm_checker u_qlm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata)
);
